// ----- hdl/bitmap_page_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// shared concurrent assertion forms for the allocator modules
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define BPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// types, constants and helpers shared by the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAP_BLOCKS  = 32768;
  localparam int BLOCK_BYTES = 4096;

  localparam int CNT_W   = 16;
  localparam int ADDR_W  = 27;
  localparam int FREE_W  = 28;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 4;

  localparam int BLK_W   = $clog2(MAP_BLOCKS);
  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int WORD_W  = 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = MAP_BLOCKS / WORD_W;
  localparam int WIDX_W  = $clog2(WORDS);
  localparam int GROUPS  = WORDS / WORD_W;
  localparam int GRP_W   = WIDX_W - BIT_W;

  localparam logic [CNT_W-1:0] MAP_BLOCKS_C       = CNT_W'(MAP_BLOCKS);
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST    = 16'd32768;
  localparam logic [CNT_W-1:0] RESERVED_COUNT_RST = 16'd1000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BLOCK_COUNT    = 4'd0;
  localparam logic [IDX_W-1:0] REG_RESERVED_COUNT = 4'd1;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_address;
    logic [FREE_W-1:0] free_bytes;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_MODIFY,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic              init_step;
    logic              capture;
    logic              pick_group;
    logic              rd_free;
    logic              rd_alloc;
    logic              commit_alloc;
    logic              commit_free;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic sweep_last;
    logic is_alloc;
    logic pool_full;
    logic free_oob;
    logic alloc_ok;
    logic free_ok;
    logic out_free;
  } dp_stat_t;

  // index of the lowest clear bit, zero when none
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hdl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bpa_dp.sv -----
// ----------------------------------------------------------------------------
// bpa_dp
// allocator datapath: usage bitmap, two summary levels, counters, result reg
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_unit_defines.svh"

module bpa_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bpa_pkg::ctl_cmd_t          cmd,
  output bpa_pkg::dp_stat_t          stat,
  input  bpa_pkg::in_req_t           in_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bpa_pkg::out_rsp_t          out_data
);

  // configuration
  logic [bpa_pkg::CNT_W-1:0] blk_count_r;
  logic [bpa_pkg::CNT_W-1:0] res_count_r;
  logic [bpa_pkg::CNT_W-1:0] total;
  logic [bpa_pkg::CNT_W-1:0] res_lim;
  logic                      cfg_hit;

  // bookkeeping
  logic [bpa_pkg::CNT_W-1:0]  used_r;
  logic [bpa_pkg::WIDX_W-1:0] sweep_r;
  logic [bpa_pkg::WORD_W-1:0] sum_r [bpa_pkg::GROUPS];
  logic [bpa_pkg::GROUPS-1:0] top_r;

  // request in flight
  logic                        op_r;
  logic [bpa_pkg::BLK_W-1:0]   blk_r;
  logic [bpa_pkg::GRP_W-1:0]   g_r;
  logic [bpa_pkg::WIDX_W-1:0]  w_r;
  logic [bpa_pkg::STAT_W-1:0]  st_r;

  // result
  logic                        out_valid_r;
  bpa_pkg::out_rsp_t           out_data_r;

  // ram
  logic                        ram_we;
  logic [bpa_pkg::WIDX_W-1:0]  ram_waddr;
  logic [bpa_pkg::WORD_W-1:0]  ram_wdata;
  logic [bpa_pkg::WIDX_W-1:0]  ram_raddr;
  logic [bpa_pkg::WORD_W-1:0]  rd_word;

  // derived
  logic [bpa_pkg::BIT_W-1:0]   s_pick;
  logic [bpa_pkg::BIT_W-1:0]   b_pick;
  logic [bpa_pkg::BLK_W-1:0]   cand;
  logic [bpa_pkg::WORD_W-1:0]  set_word;
  logic [bpa_pkg::WORD_W-1:0]  clr_word;
  logic [bpa_pkg::WORD_W-1:0]  sum_set;
  logic [bpa_pkg::CNT_W-1:0]   init_lo;
  logic [bpa_pkg::CNT_W-1:0]   init_rem;
  logic [bpa_pkg::WORD_W-1:0]  init_word;
  logic [bpa_pkg::CNT_W-1:0]   free_blocks;
  logic [bpa_pkg::BLK_W-1:0]   in_blk;

  assign total   = (blk_count_r > bpa_pkg::MAP_BLOCKS_C) ? bpa_pkg::MAP_BLOCKS_C : blk_count_r;
  assign res_lim = (res_count_r > total) ? total : res_count_r;
  assign cfg_hit = cfg_valid && (cfg_index == bpa_pkg::REG_BLOCK_COUNT ||
                                 cfg_index == bpa_pkg::REG_RESERVED_COUNT);
  assign cfg_ready = 1'b1;

  assign in_blk = in_data.address[bpa_pkg::ADDR_W-1:bpa_pkg::OFF_W];

  // init pattern: reserved low blocks set
  assign init_lo  = bpa_pkg::CNT_W'({sweep_r, {bpa_pkg::BIT_W{1'b0}}});
  assign init_rem = res_lim - init_lo;
  always_comb begin
    if (res_lim <= init_lo) begin
      init_word = '0;
    end else if (init_rem >= bpa_pkg::CNT_W'(bpa_pkg::WORD_W)) begin
      init_word = '1;
    end else begin
      init_word = ~({bpa_pkg::WORD_W{1'b1}} << init_rem[bpa_pkg::BIT_W-1:0]);
    end
  end

  assign s_pick   = bpa_pkg::first_zero(sum_r[g_r]);
  assign b_pick   = bpa_pkg::first_zero(rd_word);
  assign cand     = {w_r, b_pick};
  assign set_word = rd_word | (bpa_pkg::WORD_W'(1) << b_pick);
  assign clr_word = rd_word & ~(bpa_pkg::WORD_W'(1) << blk_r[bpa_pkg::BIT_W-1:0]);
  assign sum_set  = sum_r[g_r] | (bpa_pkg::WORD_W'(1) << w_r[bpa_pkg::BIT_W-1:0]);

  assign ram_raddr = cmd.rd_alloc ? {g_r, s_pick} : blk_r[bpa_pkg::BLK_W-1:bpa_pkg::BIT_W];
  assign ram_we    = cmd.init_step || cmd.commit_alloc || cmd.commit_free;
  assign ram_waddr = cmd.init_step ? sweep_r : w_r;
  always_comb begin
    if (cmd.init_step) begin
      ram_wdata = init_word;
    end else if (cmd.commit_alloc) begin
      ram_wdata = set_word;
    end else begin
      ram_wdata = clr_word;
    end
  end

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (bpa_pkg::WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  // configuration and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_count_r <= bpa_pkg::BLOCK_COUNT_RST;
      res_count_r <= bpa_pkg::RESERVED_COUNT_RST;
      sweep_r     <= '0;
    end else begin
      if (cfg_valid && cfg_index == bpa_pkg::REG_BLOCK_COUNT) begin
        blk_count_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == bpa_pkg::REG_RESERVED_COUNT) begin
        res_count_r <= cfg_data;
      end
      if (cfg_hit) begin
        sweep_r <= '0;
      end else if (cmd.init_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
    end
  end

  // summary levels and used count
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      used_r <= res_lim;
      sum_r[sweep_r[bpa_pkg::WIDX_W-1:bpa_pkg::BIT_W]][sweep_r[bpa_pkg::BIT_W-1:0]] <=
        &init_word;
      // words fill in order, so a group is full when its last word is
      if (&sweep_r[bpa_pkg::BIT_W-1:0]) begin
        top_r[sweep_r[bpa_pkg::WIDX_W-1:bpa_pkg::BIT_W]] <= &init_word;
      end
    end
    if (cmd.commit_alloc) begin
      used_r <= used_r + 1'b1;
      if (&set_word) begin
        sum_r[g_r][w_r[bpa_pkg::BIT_W-1:0]] <= 1'b1;
        top_r[g_r] <= &sum_set;
      end
    end
    if (cmd.commit_free) begin
      used_r <= used_r - 1'b1;
      sum_r[w_r[bpa_pkg::WIDX_W-1:bpa_pkg::BIT_W]][w_r[bpa_pkg::BIT_W-1:0]] <= 1'b0;
      top_r[w_r[bpa_pkg::WIDX_W-1:bpa_pkg::BIT_W]] <= 1'b0;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.operation;
      blk_r <= in_blk;
    end
    if (cmd.pick_group) begin
      g_r <= bpa_pkg::first_zero(top_r);
    end
    if (cmd.rd_alloc) begin
      w_r <= {g_r, s_pick};
    end
    if (cmd.rd_free) begin
      w_r <= blk_r[bpa_pkg::BLK_W-1:bpa_pkg::BIT_W];
    end
    if (cmd.commit_alloc) begin
      blk_r <= cand;
    end
    if (cmd.set_status) begin
      st_r <= cmd.status;
    end
  end

  assign free_blocks = (total >= used_r) ? (total - used_r) : '0;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.status <= st_r;
      if (op_r == bpa_pkg::OP_ALLOC && st_r == bpa_pkg::STAT_OK) begin
        out_data_r.block_address <= bpa_pkg::ADDR_W'(blk_r) << bpa_pkg::OFF_W;
      end else begin
        out_data_r.block_address <= '0;
      end
      out_data_r.free_bytes <= bpa_pkg::FREE_W'(free_blocks) << bpa_pkg::OFF_W;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.cfg_hit    = cfg_hit;
    stat.sweep_last = &sweep_r;
    stat.is_alloc   = (op_r == bpa_pkg::OP_ALLOC);
    stat.pool_full  = (used_r >= total);
    stat.free_oob   = ({1'b0, blk_r} >= total);
    stat.alloc_ok   = ({1'b0, cand} < total);
    stat.free_ok    = rd_word[blk_r[bpa_pkg::BIT_W-1:0]];
    stat.out_free   = !out_valid_r || out_ready;
  end

  `BPA_ASSERT_SAME(a_alloc_has_room, clk, rst_n, cmd.commit_alloc, used_r < total, "allocation committed with no free block")
  `BPA_ASSERT_SAME(a_free_of_used, clk, rst_n, cmd.commit_free, rd_word[blk_r[bpa_pkg::BIT_W-1:0]], "free committed on a clear bit")
  `BPA_ASSERT_NEXT(a_used_step, clk, rst_n, cmd.commit_alloc, used_r == $past(used_r) + 1'b1, "used count did not advance on allocation")
  `BPA_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_r || out_ready, "result overwritten before it was taken")

endmodule

// ----- hdl/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// allocator sequencer: init sweep, bitmap search and update, result hand-off
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::ctl_cmd_t cmd
);

  bpa_pkg::state_t state_r;
  bpa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bpa_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.sweep_last) state_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = bpa_pkg::S_CHECK;
      end
      bpa_pkg::S_CHECK: begin
        if (stat.is_alloc) begin
          if (stat.pool_full) begin
            cmd.set_status = 1'b1;
            cmd.status     = bpa_pkg::STAT_OOM;
            state_nxt      = bpa_pkg::S_REPLY;
          end else begin
            cmd.pick_group = 1'b1;
            state_nxt      = bpa_pkg::S_SUM;
          end
        end else begin
          if (stat.free_oob) begin
            cmd.set_status = 1'b1;
            cmd.status     = bpa_pkg::STAT_INVALID;
            state_nxt      = bpa_pkg::S_REPLY;
          end else begin
            cmd.rd_free = 1'b1;
            state_nxt   = bpa_pkg::S_MODIFY;
          end
        end
      end
      bpa_pkg::S_SUM: begin
        cmd.rd_alloc = 1'b1;
        state_nxt    = bpa_pkg::S_MODIFY;
      end
      bpa_pkg::S_MODIFY: begin
        cmd.set_status = 1'b1;
        if (stat.is_alloc) begin
          cmd.commit_alloc = stat.alloc_ok;
          cmd.status       = stat.alloc_ok ? bpa_pkg::STAT_OK : bpa_pkg::STAT_OOM;
        end else begin
          cmd.commit_free = stat.free_ok;
          cmd.status      = stat.free_ok ? bpa_pkg::STAT_OK : bpa_pkg::STAT_INVALID;
        end
        state_nxt = bpa_pkg::S_REPLY;
      end
      bpa_pkg::S_REPLY: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_INIT;
    endcase
    // a write to either config register restarts the init sweep
    if (stat.cfg_hit) state_nxt = bpa_pkg::S_INIT;
  end

endmodule

// ----- hdl/bitmap_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// page frame allocator over a used/free bitmap with word and group summaries
//
//   channel  direction  handshake            payload
//   in_      request    in_valid/in_ready    in_data (operation, address)
//   out_     result     out_valid/out_ready  out_data (status, address, free)
//   cfg_     register   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a request is taken only when the sequencer is idle; the result of an allocate
// passes group pick, word pick, map read-modify-write and load, a free skips the
// picks, and a full pool or an out-of-range free goes straight to the load; the
// next request can be taken the cycle after the load
// after reset and after each write to a known register the map is swept, one
// ram word a cycle; no request is accepted during the sweep
// a new request is taken while the previous result waits in the output register;
// its result then waits in the sequencer and holds off further requests
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bpa_pkg::in_req_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bpa_pkg::out_rsp_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_data
);

  bpa_pkg::ctl_cmd_t cmd;
  bpa_pkg::dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
